[rtl/pazc_pkg.sv]
// Shared types and constants for the proximity average zone classifier.
// No dependencies; every other file in the block imports this package.
package pazc_pkg;

    localparam int DATA_W     = 16;
    localparam int WINDOW_DEF = 5;
    localparam int ZONE_W     = 3;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LOW_CLAMP    = 3'd0;
    localparam logic [2:0] REG_SUBSTITUTE   = 3'd1;
    localparam logic [2:0] REG_RANGE_LIMIT  = 3'd2;
    localparam logic [2:0] REG_ALERT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_MEDIUM_LIMIT = 3'd4;

    localparam logic [DATA_W-1:0] LOW_CLAMP_RST    = 16'd50;
    localparam logic [DATA_W-1:0] SUBSTITUTE_RST   = 16'd3000;
    localparam logic [DATA_W-1:0] RANGE_LIMIT_RST  = 16'd2000;
    localparam logic [DATA_W-1:0] ALERT_LIMIT_RST  = 16'd100;
    localparam logic [DATA_W-1:0] MEDIUM_LIMIT_RST = 16'd300;

    localparam logic [ZONE_W-1:0] ZONE_TIMEOUT = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_OUT     = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_ALERT   = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_MEDIUM  = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_FAR     = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] distance_mm;
        logic              read_ok;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] mean_mm;
        logic [ZONE_W-1:0] zone;
    } out_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] low_clamp_mm;
        logic [DATA_W-1:0] substitute_mm;
        logic [DATA_W-1:0] range_limit_mm;
        logic [DATA_W-1:0] alert_limit_mm;
        logic [DATA_W-1:0] medium_limit_mm;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic write_ring;
        logic sum_step;
        logic div_step;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_ok;
        logic sum_last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

[rtl/pazc_ctrl.sv]
// Sequencer for the classifier: accept, ring write, summation, divide, result.
// Depends on pazc_pkg for the command and status structs.
module pazc_ctrl
    import pazc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    // a failed read goes straight to the result
                    state_next  = stat.in_ok ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                cmd.write_ring = 1'b1;
                state_next     = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (stat.sum_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no beat is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);

endmodule

[rtl/pazc_dpath.sv]
// Datapath: sample ring, sequential summation, restoring divider, zone compare
// and output register. Depends on pazc_pkg; driven by pazc_ctrl commands.
module pazc_dpath
    import pazc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  in_beat_t  s_data,
    input  cmd_t      cmd,
    output stat_t     stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int DIV_W  = $clog2(SUM_W);

    logic [DATA_W-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic              full_reg;
    logic [DATA_W-1:0] reading_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_cnt_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [DATA_W-1:0] sample;
    logic              wrap;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              quo_bit;
    logic [DATA_W-1:0] mean;
    logic [ZONE_W-1:0] zone;

    assign sample    = (reading_reg < cfg.low_clamp_mm) ? cfg.substitute_mm : reading_reg;
    assign wrap      = (slot_reg == SLOT_W'(WINDOW - 1));
    assign rem_shift = {rem_reg, sum_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign quo_bit   = (rem_shift >= {1'b0, count_reg});
    assign mean      = sum_reg[DATA_W-1:0];

    always_comb begin
        priority if (mean > cfg.range_limit_mm) begin
            zone = ZONE_OUT;
        end else if (mean <= cfg.alert_limit_mm) begin
            zone = ZONE_ALERT;
        end else if (mean <= cfg.medium_limit_mm) begin
            zone = ZONE_MEDIUM;
        end else begin
            zone = ZONE_FAR;
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            full_reg <= 1'b0;
        end else if (cmd.write_ring) begin
            slot_reg <= wrap ? '0 : slot_reg + SLOT_W'(1);
            if (wrap) begin
                full_reg <= 1'b1;
            end
        end
    end

    // Payload registers, no reset: ring entries are only read once written
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            reading_reg <= s_data.distance_mm;
            ok_reg      <= s_data.read_ok;
        end
        if (cmd.write_ring) begin
            ring_reg[slot_reg] <= sample;
            count_reg   <= (full_reg || wrap) ? CNT_W'(WINDOW)
                                              : CNT_W'(slot_reg) + CNT_W'(1);
            idx_reg     <= '0;
            sum_reg     <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.sum_step) begin
            sum_reg <= sum_reg + SUM_W'(ring_reg[idx_reg]);
            idx_reg <= idx_reg + SLOT_W'(1);
        end
        if (cmd.div_step) begin
            // one quotient bit a cycle, shifted into the vacated sum bits
            rem_reg     <= quo_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            sum_reg     <= {sum_reg[SUM_W-2:0], quo_bit};
            div_cnt_reg <= div_cnt_reg + DIV_W'(1);
        end
        if (cmd.load_out) begin
            m_data_reg.mean_mm <= ok_reg ? mean : '0;
            m_data_reg.zone    <= ok_reg ? zone : ZONE_TIMEOUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.in_ok    = s_data.read_ok;
    assign stat.sum_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.div_last = (div_cnt_reg == DIV_W'(SUM_W - 1));
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) < WINDOW)
        else $error("write slot beyond window");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sum_step |-> (count_reg != '0) && (32'(count_reg) <= WINDOW))
        else $error("sample count out of range during summation");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> rem_reg < count_reg)
        else $error("divider remainder not below divisor");

    a_mean_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && ok_reg |-> (sum_reg >> DATA_W) == '0)
        else $error("quotient wider than mean field");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_valid_reg || m_ready)
        else $error("result loaded over an untaken beat");

endmodule

[rtl/proximity_average_zone_classifier_core.sv]
// Top level of the proximity average zone classifier: APB register file and
// wiring of pazc_ctrl and pazc_dpath. Depends on pazc_pkg.
//
//  channel  | direction | handshake        | beat
//  s_       | in        | s_valid/s_ready  | in_beat_t  {distance_mm, read_ok}
//  m_       | out       | m_valid/m_ready  | out_beat_t {mean_mm, zone}
//  APB      | in        | psel/penable     | 16-bit registers at 4 * index
//
// A valid reading is written into the ring, summed over the filled samples
// (up to WINDOW) and divided by their count; the restoring divider yields one
// quotient bit a cycle over SUM_W = 16 + clog2(WINDOW) bits. A failed read
// skips the ring, summation and divide and goes straight to the result. One
// item is in work at a time; the next is taken once the previous result sits
// in the output register. Synchronous active-low reset empties the window and
// restores the register defaults.
module proximity_average_zone_classifier_core
    import pazc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_beat_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_beat_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [2:0]  reg_idx;
    logic        wr_en;
    logic [DATA_W-1:0] rd_val;
    cmd_t        cmd;
    stat_t       stat;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_LOW_CLAMP:    cfg_next.low_clamp_mm    = pwdata[DATA_W-1:0];
                REG_SUBSTITUTE:   cfg_next.substitute_mm   = pwdata[DATA_W-1:0];
                REG_RANGE_LIMIT:  cfg_next.range_limit_mm  = pwdata[DATA_W-1:0];
                REG_ALERT_LIMIT:  cfg_next.alert_limit_mm  = pwdata[DATA_W-1:0];
                REG_MEDIUM_LIMIT: cfg_next.medium_limit_mm = pwdata[DATA_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_clamp_mm    <= LOW_CLAMP_RST;
            cfg_reg.substitute_mm   <= SUBSTITUTE_RST;
            cfg_reg.range_limit_mm  <= RANGE_LIMIT_RST;
            cfg_reg.alert_limit_mm  <= ALERT_LIMIT_RST;
            cfg_reg.medium_limit_mm <= MEDIUM_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOW_CLAMP:    rd_val = cfg_reg.low_clamp_mm;
            REG_SUBSTITUTE:   rd_val = cfg_reg.substitute_mm;
            REG_RANGE_LIMIT:  rd_val = cfg_reg.range_limit_mm;
            REG_ALERT_LIMIT:  rd_val = cfg_reg.alert_limit_mm;
            REG_MEDIUM_LIMIT: rd_val = cfg_reg.medium_limit_mm;
            default:          rd_val = '0;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);

    pazc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pazc_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
